// ----- rtl/dpfsa_pkg.sv -----
package dpfsa_pkg;

    localparam int IDX_W = 14;
    localparam int CNT_W = 15;

    localparam int INODE_COUNT_DEF = 1024;
    localparam int BLOCK_COUNT_DEF = 16384;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef enum logic {
        ACT_ALLOC = 1'b0,
        ACT_FREE  = 1'b1
    } t_action;

    typedef enum logic {
        POOL_INODE = 1'b0,
        POOL_BLOCK = 1'b1
    } t_pool;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_DONE = 1'b1
    } t_state;

    // Request from the controller to one pool.
    typedef struct packed {
        logic             valid;
        t_action          action;
        logic             bad_index;
        logic [IDX_W-1:0] index;
    } t_req;

    // Outcome of the last request handled by one pool.
    typedef struct packed {
        t_status          status;
        logic [IDX_W-1:0] granted;
        logic [CNT_W-1:0] count;
    } t_result;

endpackage

// ----- rtl/dpfsa_stack.sv -----
module dpfsa_stack #(
    parameter int COUNT = dpfsa_pkg::BLOCK_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dpfsa_pkg::t_req    i_req,
    output dpfsa_pkg::t_result o_res
);

    localparam int AW = $clog2(COUNT);
    localparam int TW = $clog2(COUNT + 1);

    logic [dpfsa_pkg::IDX_W-1:0] mem [COUNT];

    logic [TW-1:0]               r_top;
    logic [TW-1:0]               n_top;
    logic [TW-1:0]               r_low;
    logic [TW-1:0]               n_low;
    dpfsa_pkg::t_status          r_status;
    dpfsa_pkg::t_status          n_status;
    logic                        r_pop;
    logic                        r_use_rst;
    logic [dpfsa_pkg::IDX_W-1:0] r_rst_val;
    logic [dpfsa_pkg::IDX_W-1:0] r_rd_data;
    logic [TW-1:0]               top_dec;
    logic                        empty;
    logic                        full;
    logic                        do_pop;
    logic                        do_push;

    assign empty   = (r_top == TW'(0));
    assign full    = (r_top == TW'(COUNT));
    assign top_dec = TW'(r_top - TW'(1));

    always_comb begin
        n_status = dpfsa_pkg::ST_OK;
        if (i_req.action == dpfsa_pkg::ACT_ALLOC) begin
            if (empty) begin
                n_status = dpfsa_pkg::ST_EMPTY;
            end
        end else if (full) begin
            n_status = dpfsa_pkg::ST_FULL;
        end else if (i_req.bad_index) begin
            n_status = dpfsa_pkg::ST_RANGE;
        end
    end

    assign do_pop  = i_req.valid && (i_req.action == dpfsa_pkg::ACT_ALLOC) && !empty;
    assign do_push = i_req.valid && (i_req.action == dpfsa_pkg::ACT_FREE)
                     && (n_status == dpfsa_pkg::ST_OK);

    // Slots below the lowest stack depth reached since reset were never written;
    // their reset value is computed, so the low-water mark replaces a clear.
    always_comb begin
        n_top = r_top;
        n_low = r_low;
        if (do_pop) begin
            n_top = top_dec;
            if (top_dec < r_low) begin
                n_low = top_dec;
            end
        end else if (do_push) begin
            n_top = TW'(r_top + TW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top    <= TW'(COUNT);
            r_low    <= TW'(COUNT);
            r_status <= dpfsa_pkg::ST_OK;
            r_pop    <= 1'b0;
        end else begin
            r_top <= n_top;
            r_low <= n_low;
            if (i_req.valid) begin
                r_status <= n_status;
                r_pop    <= (i_req.action == dpfsa_pkg::ACT_ALLOC);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_pop) begin
            r_use_rst <= (top_dec < r_low);
            r_rst_val <= dpfsa_pkg::IDX_W'(TW'(TW'(COUNT) - r_top));
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            mem[r_top[AW-1:0]] <= i_req.index;
        end
        if (do_pop) begin
            r_rd_data <= mem[top_dec[AW-1:0]];
        end
    end

    always_comb begin
        o_res.status  = r_status;
        o_res.granted = '0;
        if (r_pop && (r_status == dpfsa_pkg::ST_OK)) begin
            o_res.granted = r_use_rst ? r_rst_val : r_rd_data;
        end
        o_res.count = dpfsa_pkg::CNT_W'(r_top);
    end

endmodule

// ----- rtl/dual_pool_free_stack_allocator.sv -----
// Free-index allocator with two pools, inodes and data blocks, each a stack.
// Requests enter on the s_axis channel: tuser selects the action (bit 0,
// 0 allocate, 1 free) and the pool (bit 1, 0 inode, 1 data block); tdata
// carries the index to return on a free. Each request gives one result on
// m_axis: tuser is the status, tdata holds the granted index and the number
// of free entries left in the selected pool.
// The stack memory is read or written in the cycle of acceptance, and the
// registered read data forms the result, which the output register takes
// once it is free. A new request is not taken until the previous result has
// moved into the output register.
// Reset leaves both pools full, with index 0 on top. No clearing pass is
// needed: a low-water mark per pool tells untouched slots from written ones,
// so requests are taken from the first cycle after reset.
// While the receiver stalls, one result waits in the output register and one
// more may wait in the pool; after that s_axis_tready stays low.
module dual_pool_free_stack_allocator #(
    parameter int INODE_COUNT = dpfsa_pkg::INODE_COUNT_DEF,
    parameter int BLOCK_COUNT = dpfsa_pkg::BLOCK_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // [13:0] free_index, [15:14] zero
    input  logic [1:0]  s_axis_tuser,  // [0] action, [1] pool
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // [13:0] granted_index, [28:14] free_count
    output logic [1:0]  m_axis_tuser   // [1:0] status
);

    dpfsa_pkg::t_state  r_state;
    dpfsa_pkg::t_state  n_state;
    dpfsa_pkg::t_pool   r_pool;
    logic               r_out_valid;
    logic               n_out_valid;
    dpfsa_pkg::t_result r_out;
    dpfsa_pkg::t_result sel_res;
    dpfsa_pkg::t_result ino_res;
    dpfsa_pkg::t_result blk_res;
    dpfsa_pkg::t_req    ino_req;
    dpfsa_pkg::t_req    blk_req;
    logic               accept;
    logic               load_out;
    logic [dpfsa_pkg::IDX_W-1:0] in_index;

    assign s_axis_tready = (r_state == dpfsa_pkg::S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign in_index      = s_axis_tdata[dpfsa_pkg::IDX_W-1:0];

    always_comb begin
        ino_req.valid     = accept && (s_axis_tuser[1] == dpfsa_pkg::POOL_INODE);
        ino_req.action    = dpfsa_pkg::t_action'(s_axis_tuser[0]);
        ino_req.bad_index = (32'(in_index) >= 32'(INODE_COUNT));
        ino_req.index     = in_index;
        blk_req.valid     = accept && (s_axis_tuser[1] == dpfsa_pkg::POOL_BLOCK);
        blk_req.action    = dpfsa_pkg::t_action'(s_axis_tuser[0]);
        blk_req.bad_index = 1'b0;
        blk_req.index     = in_index;
    end

    dpfsa_stack #(
        .COUNT(INODE_COUNT)
    ) u_inode (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (ino_req),
        .o_res  (ino_res)
    );

    dpfsa_stack #(
        .COUNT(BLOCK_COUNT)
    ) u_block (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (blk_req),
        .o_res  (blk_res)
    );

    assign sel_res = (r_pool == dpfsa_pkg::POOL_BLOCK) ? blk_res : ino_res;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        load_out    = 1'b0;
        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            dpfsa_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = dpfsa_pkg::S_DONE;
                end
            end
            dpfsa_pkg::S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    load_out    = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = dpfsa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dpfsa_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dpfsa_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pool <= dpfsa_pkg::t_pool'(s_axis_tuser[1]);
        end
        if (load_out) begin
            r_out <= sel_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.status;
    assign m_axis_tdata  = {3'b000, r_out.count, r_out.granted};

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !s_axis_tready)
        else $error("request taken while the previous one is still in progress");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state == dpfsa_pkg::S_DONE))
        else $error("result presented without a request in progress");

    a_grant_zero_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser != dpfsa_pkg::ST_OK))
        |-> (m_axis_tdata[13:0] == 14'd0))
        else $error("non-zero index granted on a failed request");

endmodule

// ----- verif/dual_pool_free_stack_allocator_tb.sv -----
`timescale 1ns / 100ps

module dual_pool_free_stack_allocator_tb;

    import dpfsa_pkg::*;

    localparam int POOL_SIZE [2] = '{INODE_COUNT_DEF, BLOCK_COUNT_DEF};

    typedef struct {
        t_action          act;
        t_pool            pl;
        logic [IDX_W-1:0] idx;
        bit               typed;
        t_result          want;
    } t_step;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;   // [13:0] free_index, [15:14] zero
    logic [1:0]  s_axis_tuser = '0;   // [0] action, [1] pool
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;        // [13:0] granted_index, [28:14] free_count
    logic [1:0]  m_axis_tuser;        // [1:0] status

    // Shadow copy of both stacks: inode slots first, data block slots after them.
    logic [IDX_W-1:0] slots [INODE_COUNT_DEF + BLOCK_COUNT_DEF];
    int unsigned      free_cnt [2];
    logic [IDX_W-1:0] lent [2][$];
    t_result          outcome_q [$];
    t_result          head;
    int unsigned      mismatches = 0;
    bit               calm = 1'b0;

    // Directed opening: rows with a typed outcome are plain from the reset state.
    t_step steps [25] = '{
        '{ACT_FREE,  POOL_INODE, 14'h0000, 1'b1, '{ST_FULL,  14'd0, 15'd1024}},
        '{ACT_FREE,  POOL_BLOCK, 14'h3FFF, 1'b1, '{ST_FULL,  14'd0, 15'd16384}},
        '{ACT_ALLOC, POOL_INODE, 14'h0000, 1'b1, '{ST_OK,    14'd0, 15'd1023}},
        '{ACT_ALLOC, POOL_BLOCK, 14'h0000, 1'b1, '{ST_OK,    14'd0, 15'd16383}},
        '{ACT_ALLOC, POOL_INODE, 14'h3FFF, 1'b1, '{ST_OK,    14'd1, 15'd1022}},
        '{ACT_FREE,  POOL_INODE, 14'd1024, 1'b1, '{ST_RANGE, 14'd0, 15'd1022}},
        '{ACT_FREE,  POOL_INODE, 14'h3FFF, 1'b1, '{ST_RANGE, 14'd0, 15'd1022}},
        '{ACT_FREE,  POOL_INODE, 14'd1023, 1'b0, '{ST_OK,    14'd0, 15'd0}},
        '{ACT_ALLOC, POOL_INODE, 14'h0000, 1'b0, '{ST_OK,    14'd0, 15'd0}},
        '{ACT_FREE,  POOL_INODE, 14'h0000, 1'b0, '{ST_OK,    14'd0, 15'd0}},
        '{ACT_FREE,  POOL_INODE, 14'h0000, 1'b0, '{ST_OK,    14'd0, 15'd0}},
        '{ACT_FREE,  POOL_INODE, 14'd5,    1'b1, '{ST_FULL,  14'd0, 15'd1024}},
        '{ACT_ALLOC, POOL_INODE, 14'h0000, 1'b0, '{ST_OK,    14'd0, 15'd0}},
        '{ACT_ALLOC, POOL_INODE, 14'h0000, 1'b0, '{ST_OK,    14'd0, 15'd0}},
        '{ACT_FREE,  POOL_BLOCK, 14'h3FFF, 1'b0, '{ST_OK,    14'd0, 15'd0}},
        '{ACT_ALLOC, POOL_BLOCK, 14'h0000, 1'b0, '{ST_OK,    14'd0, 15'd0}},
        '{ACT_FREE,  POOL_BLOCK, 14'h2AAA, 1'b0, '{ST_OK,    14'd0, 15'd0}},
        '{ACT_FREE,  POOL_BLOCK, 14'h1555, 1'b1, '{ST_FULL,  14'd0, 15'd16384}},
        '{ACT_ALLOC, POOL_BLOCK, 14'h0000, 1'b0, '{ST_OK,    14'd0, 15'd0}},
        '{ACT_ALLOC, POOL_BLOCK, 14'h0000, 1'b0, '{ST_OK,    14'd0, 15'd0}},
        '{ACT_FREE,  POOL_INODE, 14'd1023, 1'b0, '{ST_OK,    14'd0, 15'd0}},
        '{ACT_ALLOC, POOL_INODE, 14'h0000, 1'b0, '{ST_OK,    14'd0, 15'd0}},
        '{ACT_FREE,  POOL_INODE, 14'h2AAA, 1'b1, '{ST_RANGE, 14'd0, 15'd1022}},
        '{ACT_FREE,  POOL_INODE, 14'h0155, 1'b0, '{ST_OK,    14'd0, 15'd0}},
        '{ACT_FREE,  POOL_BLOCK, 14'h1555, 1'b0, '{ST_OK,    14'd0, 15'd0}}
    };

    dual_pool_free_stack_allocator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // Pops or pushes the shadow stack of one pool and returns what the block should report.
    function automatic t_result pool_outcome(t_action act, t_pool pl, logic [IDX_W-1:0] idx);
        t_result     r;
        int unsigned base;
        base = (pl == POOL_INODE) ? 0 : INODE_COUNT_DEF;
        r = '{status: ST_OK, granted: '0, count: '0};
        if (act == ACT_ALLOC) begin
            if (free_cnt[pl] == 0) begin
                r.status = ST_EMPTY;
            end else begin
                free_cnt[pl]--;
                r.granted = slots[base + free_cnt[pl]];
                lent[pl].push_back(r.granted);
            end
        end else if (free_cnt[pl] >= POOL_SIZE[pl]) begin
            r.status = ST_FULL;
        end else if (pl == POOL_INODE && idx >= INODE_COUNT_DEF) begin
            r.status = ST_RANGE;
        end else begin
            slots[base + free_cnt[pl]] = idx;
            free_cnt[pl]++;
        end
        r.count = CNT_W'(free_cnt[pl]);
        return r;
    endfunction

    // Hands back an index that was granted earlier, so frees mostly return live indices.
    function automatic logic [IDX_W-1:0] take_lent(t_pool pl);
        int unsigned      k;
        logic [IDX_W-1:0] v;
        if (lent[pl].size() == 0) begin
            return IDX_W'($urandom_range(POOL_SIZE[pl] - 1));
        end
        k = $urandom_range(lent[pl].size() - 1);
        v = lent[pl][k];
        lent[pl][k] = lent[pl][lent[pl].size() - 1];
        void'(lent[pl].pop_back());
        return v;
    endfunction

    function automatic logic [IDX_W-1:0] noise_index(t_pool pl);
        if (pl == POOL_INODE && $urandom_range(1) == 0) begin
            return IDX_W'($urandom_range(INODE_COUNT_DEF - 1));
        end
        return IDX_W'($urandom_range(16383));
    endfunction

    task automatic send(input t_action act, input t_pool pl, input logic [IDX_W-1:0] idx,
                        input bit typed = 1'b0, input t_result want = '0);
        t_result got;
        @(negedge i_clk);
        if (!calm && $urandom_range(99) < 8) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, idx};
        s_axis_tuser  <= {pl, act};
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        got = pool_outcome(act, pl, idx);
        outcome_q.push_back(typed ? want : got);
    endtask

    // The last request is withdrawn first so that it is not taken a second time.
    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (outcome_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic flag(input string field, input int unsigned want_v, input int unsigned got_v);
        mismatches++;
        $error("%s: expected %0d, got %0d", field, want_v, got_v);
    endtask

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            m_axis_tready <= calm || ($urandom_range(99) >= 8);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (outcome_q.size() == 0) begin
                mismatches++;
                $error("result transaction with no request outstanding");
            end else begin
                head = outcome_q.pop_front();
                if (t_status'(m_axis_tuser) != head.status) begin
                    flag("status", head.status, m_axis_tuser);
                end
                if (m_axis_tdata[13:0] != head.granted) begin
                    flag("granted_index", head.granted, m_axis_tdata[13:0]);
                end
                if (m_axis_tdata[28:14] != head.count) begin
                    flag("free_count", head.count, m_axis_tdata[28:14]);
                end
            end
        end
    end

    initial begin
        t_pool            pl;
        int unsigned      r;
        for (int i = 0; i < INODE_COUNT_DEF; i++) begin
            slots[i] = IDX_W'(INODE_COUNT_DEF - 1 - i);
        end
        for (int i = 0; i < BLOCK_COUNT_DEF; i++) begin
            slots[INODE_COUNT_DEF + i] = IDX_W'(BLOCK_COUNT_DEF - 1 - i);
        end
        free_cnt[POOL_INODE] = INODE_COUNT_DEF;
        free_cnt[POOL_BLOCK] = BLOCK_COUNT_DEF;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (steps[i]) begin
            send(steps[i].act, steps[i].pl, steps[i].idx, steps[i].typed, steps[i].want);
        end
        // Hold the sender back until every outstanding transaction has been answered.
        wait_drained();

        for (int n = 0; n < 675; n++) begin
            // A stretch in the middle runs both sides flat out.
            calm = (n >= 300) && (n < 450);
            r  = $urandom_range(99);
            pl = t_pool'($urandom_range(1));
            if (r < 55) begin
                send(ACT_ALLOC, pl, noise_index(pl));
            end else if (r < 85) begin
                send(ACT_FREE, pl, take_lent(pl));
            end else begin
                send(ACT_FREE, pl, noise_index(pl));
            end
        end
        wait_drained();

        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("PASS dual_pool_free_stack_allocator");
        end else begin
            $display("FAIL dual_pool_free_stack_allocator");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("FAIL dual_pool_free_stack_allocator");
        $finish;
    end

endmodule
